@@ rtl/core/sdi_pkg.sv @@
// Shared constants, types and helpers of the sample derivative / integral unit.
package sdi_pkg;

  localparam int FRAC_BITS = 16;
  localparam int MUL_BITS  = 32;
  localparam int LO_W      = 32 + FRAC_BITS;
  localparam int B_W       = 33;
  localparam int H_W       = B_W + 1;
  localparam int CNT_W     = $clog2(LO_W + 1);
  localparam int PROD_W    = B_W + MUL_BITS;
  localparam int WIDE_W    = PROD_W + 1;
  localparam int SAT_W     = WIDE_W + 1;
  localparam int PADDR_W   = 5;

  localparam logic [CNT_W-1:0] ITER_DIV = CNT_W'(LO_W);
  localparam logic [CNT_W-1:0] ITER_MOD = CNT_W'(32);
  localparam logic [CNT_W-1:0] ITER_MUL = CNT_W'(MUL_BITS);

  localparam logic [1:0] MODE_PASS  = 2'd0;
  localparam logic [1:0] MODE_DERIV = 2'd1;
  localparam logic [1:0] MODE_TRAP  = 2'd2;
  localparam logic [1:0] MODE_SUM   = 2'd3;

  localparam logic [2:0] REG_MODE   = 3'd0;
  localparam logic [2:0] REG_WRAP   = 3'd1;
  localparam logic [2:0] REG_RANGE  = 3'd2;
  localparam logic [2:0] REG_GAIN   = 3'd3;
  localparam logic [2:0] REG_OFFSET = 3'd4;

  localparam logic signed [SAT_W-1:0] SAT_HI = {{(SAT_W-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [SAT_W-1:0] SAT_LO = {{(SAT_W-31){1'b1}}, {31{1'b0}}};

  typedef enum logic {
    OP_MUL = 1'b0,
    OP_DIV = 1'b1
  } sdi_op_e;

  typedef struct packed {
    logic             start;
    sdi_op_e          op;
    logic [CNT_W-1:0] iters;
  } sdi_req_t;

  function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] x);
    logic signed [31:0] r;
    if (x > SAT_HI) begin
      r = 32'sh7fff_ffff;
    end else if (x < SAT_LO) begin
      r = 32'sh8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/core/sdi_shift_unit.sv @@
// Shared shift-add multiplier and restoring divider, one bit per cycle.
module sdi_shift_unit import sdi_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sdi_req_t         req_i,
  input  logic [LO_W-1:0]  a_i,
  input  logic [B_W-1:0]   b_i,
  output logic             done_o,
  output logic [H_W-1:0]   hi_o,
  output logic [LO_W-1:0]  lo_o
);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  sdi_op_e          op_q;
  logic [H_W-1:0]   hi_q, hi_d;
  logic [LO_W-1:0]  lo_q, lo_d;
  logic [B_W-1:0]   b_q;

  logic [H_W-1:0]   rem_sh;
  logic [H_W-1:0]   opa, opb;
  logic             cin;
  logic [H_W:0]     sum;

  always_comb begin
    rem_sh = {hi_q[B_W-1:0], lo_q[LO_W-1]};
    if (op_q == OP_DIV) begin
      opa = rem_sh;
      opb = ~{1'b0, b_q};
      cin = 1'b1;
    end else begin
      opa = hi_q;
      opb = lo_q[0] ? {1'b0, b_q} : '0;
      cin = 1'b0;
    end
    sum = {1'b0, opa} + {1'b0, opb} + (H_W+1)'(cin);
    if (op_q == OP_DIV) begin
      hi_d = sum[H_W] ? sum[H_W-1:0] : rem_sh;
      lo_d = {lo_q[LO_W-2:0], sum[H_W]};
    end else begin
      hi_d = {1'b0, sum[H_W-1:1]};
      lo_d = {sum[0], lo_q[LO_W-1:1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= OP_MUL;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.iters;
        op_q   <= req_i.op;
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      hi_q <= '0;
      lo_q <= a_i;
      b_q  <= b_i;
    end else if (busy_q) begin
      hi_q <= hi_d;
      lo_q <= lo_d;
    end
  end

  assign done_o = done_q;
  assign hi_o   = hi_q;
  assign lo_o   = lo_q;

endmodule

@@ rtl/core/sample_derivative_integral_unit.sv @@
// Top level of the sample derivative / integral unit.
// One timestamped Q16.16 sample per transfer in, one result per transfer out.
// The unit takes one item at a time: s_axis_tready is high only while idle,
// and stays low until the result transfer on m_axis completes. All heavy
// arithmetic runs on one shared shift-add/subtract unit, one bit per cycle:
// the multiplications and the derivative division. An angle wrap adds
// a modulo plus a fix-up step. Invalid results skip the scaling
// multiplication. Writing transform_mode restarts the history.
module sample_derivative_integral_unit import sdi_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [63:0]        s_axis_tdata,  // sample[31:0], sample_time[63:32]
  input  logic [1:0]         s_axis_tuser,  // sample_ok[0], first_sample[1]
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [63:0]        m_axis_tdata,  // result_value[31:0], scaled_value[63:32]
  output logic               m_axis_tuser,  // result_valid
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  typedef enum logic [12:0] {
    S_IDLE      = 13'b0000000000001,
    S_PREP      = 13'b0000000000010,
    S_WRAP      = 13'b0000000000100,
    S_FOLD      = 13'b0000000001000,
    S_CALC      = 13'b0000000010000,
    S_DIVIDE    = 13'b0000000100000,
    S_PRODUCT   = 13'b0000001000000,
    S_ACCUM     = 13'b0000010000000,
    S_SCALE_GO  = 13'b0000100000000,
    S_SCALE     = 13'b0001000000000,
    S_SCALE_ADD = 13'b0010000000000,
    S_FINISH    = 13'b0100000000000,
    S_OUT       = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [1:0]         mode_q;
  logic               wrap_q;
  logic [30:0]        range_q;
  logic signed [31:0] gain_q;
  logic signed [31:0] offset_q;

  // history
  logic signed [31:0] last_raw_q;
  logic               last_raw_ok_q;
  logic signed [31:0] last_res_q;
  logic               last_res_ok_q;
  logic [31:0]        last_time_q;

  // item in flight
  logic signed [31:0]       raw_q;
  logic                     ok_q;
  logic                     first_q;
  logic [31:0]              time_q;
  logic signed [32:0]       dt_q;
  logic signed [32:0]       diff_q, diff_d;
  logic                     neg_q, neg_d;
  logic signed [31:0]       res_q, res_d;
  logic                     valid_q, valid_d;
  logic signed [31:0]       scaled_q, scaled_d;
  logic signed [WIDE_W-1:0] wide_q, wide_d;
  logic                     commit;

  // shared unit
  sdi_req_t        req;
  logic [LO_W-1:0] op_a;
  logic [B_W-1:0]  op_b;
  logic            u_done;
  logic [H_W-1:0]  u_hi;
  logic [LO_W-1:0] u_lo;

  logic                     accept;
  logic                     cfg_wr;
  logic [2:0]               reg_idx;
  logic signed [31:0]       s_sample;
  logic signed [32:0]       s_diff;
  logic signed [32:0]       diff_neg, dt_neg;
  logic [31:0]              diff_mag, dt_mag;
  logic signed [33:0]       s_sum, s_neg;
  logic [32:0]              s_mag;
  logic signed [34:0]       sum3;
  logic signed [32:0]       res_ext, res_neg;
  logic [31:0]              res_mag;
  logic signed [32:0]       gain_ext, gain_neg;
  logic [31:0]              gain_mag;
  logic [PROD_W-1:0]        prod;
  logic signed [WIDE_W-1:0] prod_ext, prod_s;
  logic [30:0]              m_rem, m_fix;
  logic [31:0]              q_neg;
  logic                     q_over_pos, q_over_neg;
  logic signed [31:0]       div_res;
  logic signed [SAT_W-1:0]  acc_sum, scl_sum;

  assign accept   = s_axis_tvalid & s_axis_tready;
  assign cfg_wr   = psel & penable & pwrite & pready;
  assign reg_idx  = paddr[PADDR_W-1:2];
  assign s_sample = s_axis_tdata[31:0];
  assign s_diff   = 33'(s_sample) - 33'(last_raw_q);

  assign diff_neg = -diff_q;
  assign diff_mag = diff_q[32] ? diff_neg[31:0] : diff_q[31:0];
  assign dt_neg   = -dt_q;
  assign dt_mag   = dt_q[32] ? dt_neg[31:0] : dt_q[31:0];

  assign s_sum = (last_res_ok_q && wrap_q)
               ? 34'(last_raw_q) + 34'(last_raw_q) + 34'(diff_q)
               : 34'(last_raw_q) + 34'(raw_q);
  assign s_neg = -s_sum;
  assign s_mag = s_sum[33] ? s_neg[32:0] : s_sum[32:0];

  always_comb begin
    if (first_q || !last_raw_ok_q) begin
      sum3 = 35'(raw_q);
    end else if (last_res_ok_q) begin
      sum3 = wrap_q ? 35'(last_res_q) + 35'(last_raw_q) + 35'(diff_q)
                    : 35'(last_res_q) + 35'(raw_q);
    end else begin
      sum3 = 35'(last_raw_q) + 35'(raw_q);
    end
  end

  assign res_ext  = 33'(res_q);
  assign res_neg  = -res_ext;
  assign res_mag  = res_q[31] ? res_neg[31:0] : res_ext[31:0];
  assign gain_ext = 33'(gain_q);
  assign gain_neg = -gain_ext;
  assign gain_mag = gain_q[31] ? gain_neg[31:0] : gain_ext[31:0];

  assign prod     = {u_hi[B_W-1:0], u_lo[LO_W-1 -: MUL_BITS]};
  assign prod_ext = $signed({1'b0, prod});
  assign prod_s   = neg_q ? -prod_ext : prod_ext;

  // remainder fix-up for a negative difference
  assign m_rem = u_hi[30:0];
  assign m_fix = (neg_q && (m_rem != '0)) ? range_q - m_rem : m_rem;

  // quotient magnitude to saturated signed result
  assign q_over_pos = |u_lo[LO_W-1:31];
  assign q_over_neg = (|u_lo[LO_W-1:32]) || (u_lo[31] && (|u_lo[30:0]));
  assign q_neg      = -u_lo[31:0];
  always_comb begin
    if (neg_q) begin
      div_res = q_over_neg ? 32'sh8000_0000 : $signed(q_neg);
    end else begin
      div_res = q_over_pos ? 32'sh7fff_ffff : $signed(u_lo[31:0]);
    end
  end

  assign acc_sum = SAT_W'(wide_q >>> (FRAC_BITS + 1))
                 + (last_res_ok_q ? SAT_W'(last_res_q) : SAT_W'(0));
  assign scl_sum = SAT_W'(wide_q >>> FRAC_BITS) + SAT_W'(offset_q);

  always_comb begin
    state_d  = state_q;
    diff_d   = diff_q;
    neg_d    = neg_q;
    res_d    = res_q;
    valid_d  = valid_q;
    scaled_d = scaled_q;
    wide_d   = wide_q;
    commit   = 1'b0;
    req      = '0;
    op_a     = '0;
    op_b     = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          diff_d  = s_diff;
          state_d = S_PREP;
        end
      end
      S_PREP: begin
        if (ok_q && wrap_q && (range_q != '0)) begin
          req.start = 1'b1;
          req.op    = OP_DIV;
          req.iters = ITER_MOD;
          op_a      = {diff_mag, {FRAC_BITS{1'b0}}};
          op_b      = B_W'(range_q);
          neg_d     = diff_q[32];
          state_d   = S_WRAP;
        end else begin
          state_d = S_CALC;
        end
      end
      S_WRAP: begin
        if (u_done) begin
          diff_d  = $signed({2'b00, m_fix});
          state_d = S_FOLD;
        end
      end
      S_FOLD: begin
        if ({diff_q[30:0], 1'b0} > {1'b0, range_q}) begin
          diff_d = $signed({2'b00, diff_q[30:0]}) - $signed({2'b00, range_q});
        end
        state_d = S_CALC;
      end
      S_CALC: begin
        res_d    = '0;
        valid_d  = 1'b0;
        scaled_d = '0;
        if (!ok_q) begin
          state_d = S_FINISH;
        end else begin
          case (mode_q)
            MODE_PASS: begin
              res_d   = raw_q;
              valid_d = 1'b1;
              state_d = S_SCALE_GO;
            end
            MODE_DERIV: begin
              if (first_q || (dt_q == '0) || !last_raw_ok_q) begin
                state_d = S_FINISH;
              end else begin
                req.start = 1'b1;
                req.op    = OP_DIV;
                req.iters = ITER_DIV;
                op_a      = {diff_mag, {FRAC_BITS{1'b0}}};
                op_b      = {1'b0, dt_mag};
                neg_d     = diff_q[32] ^ dt_q[32];
                valid_d   = 1'b1;
                state_d   = S_DIVIDE;
              end
            end
            MODE_TRAP: begin
              valid_d = 1'b1;
              if (first_q || !last_raw_ok_q) begin
                state_d = S_SCALE_GO;
              end else begin
                req.start = 1'b1;
                req.op    = OP_MUL;
                req.iters = ITER_MUL;
                op_a      = LO_W'(dt_mag);
                op_b      = s_mag;
                neg_d     = s_sum[33] ^ dt_q[32];
                state_d   = S_PRODUCT;
              end
            end
            MODE_SUM: begin
              res_d   = sat32(SAT_W'(sum3));
              valid_d = 1'b1;
              state_d = S_SCALE_GO;
            end
            default: begin
              state_d = S_FINISH;
            end
          endcase
        end
      end
      S_DIVIDE: begin
        if (u_done) begin
          res_d   = div_res;
          state_d = S_SCALE_GO;
        end
      end
      S_PRODUCT: begin
        if (u_done) begin
          wide_d  = prod_s;
          state_d = S_ACCUM;
        end
      end
      S_ACCUM: begin
        res_d   = sat32(acc_sum);
        state_d = S_SCALE_GO;
      end
      S_SCALE_GO: begin
        req.start = 1'b1;
        req.op    = OP_MUL;
        req.iters = ITER_MUL;
        op_a      = LO_W'(res_mag);
        op_b      = B_W'(gain_mag);
        neg_d     = res_q[31] ^ gain_q[31];
        state_d   = S_SCALE;
      end
      S_SCALE: begin
        if (u_done) begin
          wide_d  = prod_s;
          state_d = S_SCALE_ADD;
        end
      end
      S_SCALE_ADD: begin
        scaled_d = sat32(scl_sum);
        state_d  = S_FINISH;
      end
      S_FINISH: begin
        commit  = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (m_axis_tready) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  sdi_shift_unit u_shift (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .a_i    (op_a),
    .b_i    (op_b),
    .done_o (u_done),
    .hi_o   (u_hi),
    .lo_o   (u_lo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      raw_q   <= s_sample;
      ok_q    <= s_axis_tuser[0];
      first_q <= s_axis_tuser[1];
      time_q  <= s_axis_tdata[63:32];
      dt_q    <= $signed({1'b0, s_axis_tdata[63:32]}) - $signed({1'b0, last_time_q});
    end
    diff_q   <= diff_d;
    neg_q    <= neg_d;
    res_q    <= res_d;
    valid_q  <= valid_d;
    scaled_q <= scaled_d;
    wide_q   <= wide_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= MODE_PASS;
      wrap_q        <= 1'b0;
      range_q       <= 31'd411775;
      gain_q        <= 32'sd65536;
      offset_q      <= '0;
      last_raw_q    <= '0;
      last_raw_ok_q <= 1'b0;
      last_res_q    <= '0;
      last_res_ok_q <= 1'b0;
      last_time_q   <= '0;
    end else begin
      if (commit) begin
        last_raw_q    <= ok_q ? raw_q : '0;
        last_raw_ok_q <= ok_q;
        last_res_q    <= res_q;
        last_res_ok_q <= valid_q;
        last_time_q   <= time_q;
      end
      if (cfg_wr) begin
        case (reg_idx)
          REG_MODE: begin
            mode_q        <= pwdata[1:0];
            last_raw_q    <= '0;
            last_raw_ok_q <= 1'b0;
            last_res_q    <= '0;
            last_res_ok_q <= 1'b0;
          end
          REG_WRAP:   wrap_q   <= pwdata[0];
          REG_RANGE:  range_q  <= pwdata[30:0];
          REG_GAIN:   gain_q   <= pwdata;
          REG_OFFSET: offset_q <= pwdata;
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MODE:   prdata = {30'b0, mode_q};
      REG_WRAP:   prdata = {31'b0, wrap_q};
      REG_RANGE:  prdata = {1'b0, range_q};
      REG_GAIN:   prdata = gain_q;
      REG_OFFSET: prdata = offset_q;
      default:    prdata = '0;
    endcase
  end

  assign pready        = 1'b1;
  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = (state_q == S_OUT);
  assign m_axis_tdata  = {scaled_q, res_q};
  assign m_axis_tuser  = valid_q;

endmodule

@@ rtl/core/sdi_checker.sv @@
// Port-level checks of the sample derivative / integral unit, bound to the top level.
module sdi_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // one item in flight: no new transfer while a result waits
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input ready while result pending");

  // an accepted item keeps the unit busy in the cycle after the transfer
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready && !m_axis_tvalid)
    else $error("unit not busy after input transfer");

  // invalid results carry zero value and zero scaled copy
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 64'd0)
    else $error("invalid result with non-zero data");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

endmodule

bind sample_derivative_integral_unit sdi_checker u_sdi_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
